/* hw/rtl/voice_command_frame_parser_defines.svh */
// Assertion macros for the voice command frame parser checker.
// No dependencies; included by the checker file only.
`ifndef VOICE_COMMAND_FRAME_PARSER_DEFINES_SVH
`define VOICE_COMMAND_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VCFP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("vcfp check failed");

// Next-cycle implication, disabled while reset is asserted.
`define VCFP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("vcfp check failed");

`endif

/* hw/rtl/vcfp_pkg.sv */
// Shared constants and types of the voice command frame parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package vcfp_pkg;

    localparam int BYTE_W     = 8;
    localparam int CODE_W     = 6;
    localparam int DATA_W     = 7;
    localparam int MS_W       = 10;
    localparam int SEC_W      = 16;
    localparam int POS_W      = 3;
    localparam int M_TDATA_W  = 32;
    localparam int M_TUSER_W  = 2;

    // Header and field limits of a frame
    localparam logic [BYTE_W-1:0] HDR0       = 8'hA5;
    localparam logic [BYTE_W-1:0] HDR1       = 8'hFA;
    localparam logic [BYTE_W-1:0] HDR2       = 8'h00;
    localparam logic [BYTE_W-1:0] HDR3       = 8'h81;
    localparam logic [BYTE_W-1:0] SEP_BYTE   = 8'h00;
    localparam logic [BYTE_W-1:0] WAKE_CODE  = 8'h01;
    localparam logic [BYTE_W-1:0] CODE_LIMIT = 8'h40;
    localparam logic [BYTE_W-1:0] DATA_LOW   = 8'h21;
    localparam logic [BYTE_W-1:0] DATA_LIMIT = 8'h60;

    // Timebase
    localparam logic [MS_W-1:0]  MS_LAST = 10'd999;
    localparam logic [SEC_W-1:0] SEC_MAX = 16'hFFFF;

    // Input kinds carried in s_tuser
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic wake_event;
        logic command_event;
    } parse_evt_t;

endpackage

/* hw/rtl/vcfp_parser.sv */
// Frame parser: header match, wake flag, code and data stores.
// Depends on vcfp_pkg.
`timescale 1ns / 1ps

module vcfp_parser
    import vcfp_pkg::*;
(
    input  logic              clk,
    input  logic              rstn,
    input  logic              step_en,
    input  logic [BYTE_W-1:0] rx_byte,
    output parse_evt_t        evt,
    output logic [CODE_W-1:0] code_next,
    output logic [DATA_W-1:0] data_next,
    output logic              wake_next
);

    localparam logic [POS_W-1:0] POS_HDR0 = 3'd0;
    localparam logic [POS_W-1:0] POS_HDR1 = 3'd1;
    localparam logic [POS_W-1:0] POS_HDR2 = 3'd2;
    localparam logic [POS_W-1:0] POS_HDR3 = 3'd3;
    localparam logic [POS_W-1:0] POS_CODE = 3'd4;
    localparam logic [POS_W-1:0] POS_SEP  = 3'd5;
    localparam logic [POS_W-1:0] POS_DATA = 3'd6;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              wake_reg;
    logic [CODE_W-1:0] code_reg;
    logic [DATA_W-1:0] data_reg;
    logic              code_ok, data_ok;

    assign code_ok = (rx_byte != 8'h00) && (rx_byte < CODE_LIMIT);
    assign data_ok = (rx_byte > DATA_LOW) && (rx_byte < DATA_LIMIT);

    always_comb begin
        pos_next  = pos_reg;
        wake_next = wake_reg;
        code_next = code_reg;
        data_next = data_reg;
        evt       = '0;
        if (step_en) begin
            unique case (pos_reg)
                POS_HDR0: pos_next = (rx_byte == HDR0) ? POS_HDR1 : POS_HDR0;
                POS_HDR1: pos_next = (rx_byte == HDR1) ? POS_HDR2 : POS_HDR0;
                POS_HDR2: pos_next = (rx_byte == HDR2) ? POS_HDR3 : POS_HDR0;
                POS_HDR3: pos_next = (rx_byte == HDR3) ? POS_CODE : POS_HDR0;
                POS_CODE: begin
                    if (rx_byte == WAKE_CODE) begin
                        wake_next      = 1'b1;
                        code_next      = rx_byte[CODE_W-1:0];
                        pos_next       = POS_HDR0;
                        evt.wake_event = 1'b1;
                    end else if (wake_reg) begin
                        // armed: take a valid code, hold position otherwise
                        if (code_ok) begin
                            code_next = rx_byte[CODE_W-1:0];
                            pos_next  = POS_SEP;
                        end
                    end else begin
                        pos_next = POS_HDR0;
                    end
                end
                POS_SEP:  pos_next = (rx_byte == SEP_BYTE) ? POS_DATA : POS_HDR0;
                POS_DATA: begin
                    if (wake_reg) begin
                        if (data_ok) begin
                            data_next         = rx_byte[DATA_W-1:0];
                            pos_next          = POS_HDR0;
                            evt.command_event = 1'b1;
                        end
                    end else begin
                        pos_next = POS_HDR0;
                    end
                end
                default:  pos_next = POS_HDR0;
            endcase
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            pos_reg  <= POS_HDR0;
            wake_reg <= 1'b0;
            code_reg <= '0;
            data_reg <= '0;
        end else begin
            pos_reg  <= pos_next;
            wake_reg <= wake_next;
            code_reg <= code_next;
            data_reg <= data_next;
        end
    end

endmodule

/* hw/rtl/vcfp_timer.sv */
// Millisecond to second divider and saturating idle seconds counter.
// Depends on vcfp_pkg.
`timescale 1ns / 1ps

module vcfp_timer
    import vcfp_pkg::*;
(
    input  logic             clk,
    input  logic             rstn,
    input  logic             tick_en,
    input  logic             clear,
    output logic [SEC_W-1:0] sec_next
);

    logic [MS_W-1:0]  ms_reg, ms_next;
    logic [SEC_W-1:0] sec_reg;

    always_comb begin
        ms_next  = ms_reg;
        sec_next = sec_reg;
        if (tick_en) begin
            if (ms_reg >= MS_LAST) begin
                ms_next = '0;
                if (sec_reg != SEC_MAX) begin
                    sec_next = sec_reg + 1'b1;
                end
            end else begin
                ms_next = ms_reg + 1'b1;
            end
        end else if (clear) begin
            sec_next = '0;
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            ms_reg  <= '0;
            sec_reg <= '0;
        end else begin
            ms_reg  <= ms_next;
            sec_reg <= sec_next;
        end
    end

endmodule

/* hw/rtl/voice_command_frame_parser.sv */
// Top level of the voice command frame parser: stream ports, input and result registers.
// Depends on vcfp_pkg, vcfp_parser and vcfp_timer.
`timescale 1ns / 1ps

// The block takes one request per cycle on the s_ channel, either a byte received from the
// voice module (s_tuser = 0) or a one millisecond tick (s_tuser = 1), as long as the input
// register is empty or the result register can advance. Every request gives exactly one
// result on the m_ channel, after it has passed through the input register and then the
// result register. A single parse and count step between the two registers updates the
// frame position, wake flag, code and data stores and the timebase once per request. Bytes
// must match the header A5 FA 00 81; then 01 is a wake frame, or (once woken) a code 02..3F,
// a 00 and a data byte 22..5F form a command frame. The result carries the event flags in
// m_tuser and the stores and the saturating count of whole seconds since the last wake or
// command in m_tdata. The wake flag is cleared only by reset. A stalled result does not
// block input: the input register still takes a request while the result register is full,
// and holds it until the result is taken.

module voice_command_frame_parser
    import vcfp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [BYTE_W-1:0]    s_tdata,   // [7:0] rx_byte
    input  logic                 s_tuser,   // [0] op: 0 byte, 1 tick
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [5:0] command_code, [12:6] command_data,
                                            // [13] wake_active, [29:14] idle_seconds,
                                            // [31:30] zero
    output logic [M_TUSER_W-1:0] m_tuser    // [0] wake_event, [1] command_event
);

    logic                 in_valid_reg;
    logic                 in_op_reg;
    logic [BYTE_W-1:0]    in_byte_reg;
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_tdata_reg, out_tdata_next;
    logic [M_TUSER_W-1:0] out_tuser_reg, out_tuser_next;

    logic                 advance;
    logic                 load_in;
    logic                 fire;
    logic                 byte_step;
    logic                 tick_step;
    parse_evt_t           evt;
    logic [CODE_W-1:0]    code_next;
    logic [DATA_W-1:0]    data_next;
    logic                 wake_next;
    logic [SEC_W-1:0]     sec_next;

    // Advance the input register whenever the result register is free or being drained.
    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign load_in   = s_tvalid && s_tready;
    assign fire      = in_valid_reg && advance;
    assign byte_step = fire && (in_op_reg == OP_BYTE);
    assign tick_step = fire && (in_op_reg == OP_TICK);

    vcfp_parser u_parser (
        .clk       (aclk),
        .rstn      (aresetn),
        .step_en   (byte_step),
        .rx_byte   (in_byte_reg),
        .evt       (evt),
        .code_next (code_next),
        .data_next (data_next),
        .wake_next (wake_next)
    );

    // A completed wake or command frame restarts the idle count.
    vcfp_timer u_timer (
        .clk      (aclk),
        .rstn     (aresetn),
        .tick_en  (tick_step),
        .clear    (evt.wake_event || evt.command_event),
        .sec_next (sec_next)
    );

    // Pack the result: state after this request.
    assign out_tdata_next = {2'b00, sec_next, wake_next, data_next, code_next};
    assign out_tuser_next = {evt.command_event, evt.wake_event};

    // Input register: hold the request until it moves into the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_in) begin
            in_op_reg   <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    // Result register: hold while the consumer stalls.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_tdata_reg <= out_tdata_next;
            out_tuser_reg <= out_tuser_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_tdata_reg;
    assign m_tuser  = out_tuser_reg;

endmodule

/* hw/rtl/vcfp_checker.sv */
// Port-level checks of the voice command frame parser, bound to the top level.
// Depends on vcfp_pkg and voice_command_frame_parser_defines.svh.
`timescale 1ns / 1ps
`include "voice_command_frame_parser_defines.svh"

module vcfp_checker
    import vcfp_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser
);

    // One request completes at most one kind of frame.
    `VCFP_ASSERT_IMP(a_one_event, aclk, aresetn, m_tvalid, !(m_tuser[0] && m_tuser[1]))

    // A wake frame arms the flag and stores code 01.
    `VCFP_ASSERT_IMP(a_wake_state, aclk, aresetn, m_tvalid && m_tuser[0],
        m_tdata[13] && (m_tdata[5:0] == 6'd1) && (m_tdata[29:14] == 16'd0))

    // A command frame is only taken when armed and restarts the idle count.
    `VCFP_ASSERT_IMP(a_cmd_state, aclk, aresetn, m_tvalid && m_tuser[1],
        m_tdata[13] && (m_tdata[29:14] == 16'd0))

    // A stalled result holds.
    `VCFP_ASSERT_NXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind voice_command_frame_parser vcfp_checker u_vcfp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* sim/tb_top.sv */
// Self-checking bench for voice_command_frame_parser: frame, wake and tick requests in,
// predicted parser results compared field by field. Depends on vcfp_pkg and the RTL only.
`timescale 1ns / 1ps

module tb_top;
    import vcfp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 80;   // receiver hold-off, long enough to back up the input
    localparam int SETTLE      = 6;    // two-stage pipe plus margin

    // Parser position inside a frame; position 7 is never entered
    typedef enum logic [POS_W-1:0] {
        FP_SYNC0 = 3'd0,
        FP_SYNC1 = 3'd1,
        FP_SYNC2 = 3'd2,
        FP_SYNC3 = 3'd3,
        FP_CODE  = 3'd4,
        FP_SEP   = 3'd5,
        FP_DATA  = 3'd6
    } frame_pos_t;

    typedef struct {
        logic              wake_ev;
        logic              cmd_ev;
        logic [CODE_W-1:0] code;
        logic [DATA_W-1:0] data;
        logic              armed;
        logic [SEC_W-1:0]  secs;
    } parse_result_t;

    // Tracks the parser state and the results still owed by the block.
    class voice_frame_checker;
        frame_pos_t        pos       = FP_SYNC0;
        logic              armed     = 1'b0;
        logic [CODE_W-1:0] code_q    = '0;
        logic [DATA_W-1:0] data_q    = '0;
        logic [MS_W-1:0]   ms_count  = '0;
        logic [SEC_W-1:0]  sec_count = '0;
        parse_result_t     pending_results[$];
        int unsigned       failures  = 0;

        function void take_request(logic op, logic [BYTE_W-1:0] rx);
            parse_result_t r;
            r.wake_ev = 1'b0;
            r.cmd_ev  = 1'b0;
            if (op == OP_TICK) begin
                // Roll the millisecond count over at 999 and bump seconds, saturating
                if (ms_count >= MS_LAST) begin
                    ms_count = '0;
                    if (sec_count != SEC_MAX)
                        sec_count = sec_count + 1'b1;
                end else begin
                    ms_count = ms_count + 1'b1;
                end
            end else begin
                case (pos)
                    FP_SYNC0: pos = (rx == HDR0) ? FP_SYNC1 : FP_SYNC0;
                    FP_SYNC1: pos = (rx == HDR1) ? FP_SYNC2 : FP_SYNC0;
                    FP_SYNC2: pos = (rx == HDR2) ? FP_SYNC3 : FP_SYNC0;
                    FP_SYNC3: pos = (rx == HDR3) ? FP_CODE  : FP_SYNC0;
                    FP_CODE: begin
                        if (rx == WAKE_CODE) begin
                            armed     = 1'b1;
                            code_q    = rx[CODE_W-1:0];
                            sec_count = '0;
                            pos       = FP_SYNC0;
                            r.wake_ev = 1'b1;
                        end else if (armed) begin
                            // Out-of-range codes leave the parser waiting here
                            if (rx != 8'h00 && rx < CODE_LIMIT) begin
                                code_q = rx[CODE_W-1:0];
                                pos    = FP_SEP;
                            end
                        end else begin
                            pos = FP_SYNC0;
                        end
                    end
                    FP_SEP: pos = (rx == SEP_BYTE) ? FP_DATA : FP_SYNC0;
                    FP_DATA: begin
                        if (armed) begin
                            if (rx > DATA_LOW && rx < DATA_LIMIT) begin
                                data_q    = rx[DATA_W-1:0];
                                sec_count = '0;
                                pos       = FP_SYNC0;
                                r.cmd_ev  = 1'b1;
                            end
                        end else begin
                            pos = FP_SYNC0;
                        end
                    end
                    default: pos = FP_SYNC0;
                endcase
            end
            r.code  = code_q;
            r.data  = data_q;
            r.armed = armed;
            r.secs  = sec_count;
            pending_results.push_back(r);
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", field, want, got);
                failures++;
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] tdata, logic [M_TUSER_W-1:0] tuser);
            parse_result_t want;
            if (pending_results.size() == 0) begin
                $error("unrequested result: tdata %h tuser %h", tdata, tuser);
                failures++;
                return;
            end
            want = pending_results.pop_front();
            compare("wake_event", want.wake_ev, tuser[0]);
            compare("command_event", want.cmd_ev, tuser[1]);
            compare("command_code", want.code, tdata[5:0]);
            compare("command_data", want.data, tdata[12:6]);
            compare("wake_active", want.armed, tdata[13]);
            compare("idle_seconds", want.secs, tdata[29:14]);
            compare("tdata_pad", 2'b00, tdata[31:30]);
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [BYTE_W-1:0]    s_tdata  = '0;
    logic                 s_tuser  = OP_BYTE;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    voice_frame_checker frame_check = new();

    int unsigned src_idle_pct = 0;
    int unsigned snk_idle_pct = 0;
    int unsigned items_sent   = 0;
    int unsigned cycle_count  = 0;
    int unsigned hold_left    = 0;
    bit          hold_request = 1'b0;

    voice_command_frame_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side: a requested long hold-off wins over the random stalls
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_request) begin
            hold_request = 1'b0;
            m_tready  <= 1'b0;
            hold_left <= LONG_HOLD;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Check every result taken at this edge
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            frame_check.check_result(m_tdata, m_tuser);
    end

    // Offer one request, idling at random first; return at the edge that accepts it.
    task automatic send(logic op, logic [BYTE_W-1:0] value);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        frame_check.take_request(op, value);
        items_sent++;
    endtask

    task automatic send_byte(logic [BYTE_W-1:0] value);
        send(OP_BYTE, value);
    endtask

    // Tick requests carry a random, ignored byte
    task automatic send_tick();
        send(OP_TICK, BYTE_W'($urandom_range(255)));
    endtask

    task automatic send_header();
        send_byte(HDR0);
        send_byte(HDR1);
        send_byte(HDR2);
        send_byte(HDR3);
    endtask

    // Drop valid and hold until every owed result is back, then let the pipe settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (frame_check.pending_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Mostly well-formed frames with random content, plus broken frames, noise and ticks
    task automatic run_phase(int unsigned src_pct, int unsigned snk_pct, int unsigned count);
        int unsigned target;
        int unsigned pick;
        int unsigned k;
        logic [BYTE_W-1:0] code;
        logic [BYTE_W-1:0] prefix[6];
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        target = items_sent + count;
        while (items_sent < target) begin
            pick = $urandom_range(99);
            code = BYTE_W'($urandom_range(2, 63));
            if (pick < 40) begin
                // Command frame, sometimes padded with out-of-range code and data bytes
                send_header();
                repeat ($urandom_range(2)) begin
                    if ($urandom_range(1) != 0)
                        send_byte(8'h00);
                    else
                        send_byte(BYTE_W'($urandom_range(8'h40, 8'hFF)));
                end
                send_byte(code);
                send_byte(SEP_BYTE);
                repeat ($urandom_range(2)) begin
                    if ($urandom_range(1) != 0)
                        send_byte(BYTE_W'($urandom_range(8'h00, 8'h21)));
                    else
                        send_byte(BYTE_W'($urandom_range(8'h60, 8'hFF)));
                end
                send_byte(BYTE_W'($urandom_range(8'h22, 8'h5F)));
            end else if (pick < 55) begin
                send_header();
                send_byte(WAKE_CODE);
            end else if (pick < 70) begin
                // Good prefix cut short by a random byte
                prefix = '{HDR0, HDR1, HDR2, HDR3, code, SEP_BYTE};
                k = $urandom_range(1, 5);
                for (int i = 0; i < k; i++)
                    send_byte(prefix[i]);
                send_byte(BYTE_W'($urandom_range(255)));
            end else if (pick < 80) begin
                repeat ($urandom_range(1, 4))
                    send_byte(BYTE_W'($urandom_range(255)));
            end else begin
                repeat ($urandom_range(1, 40))
                    send_tick();
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part; start with a long result hold so the input backs up
        src_idle_pct = 20;
        snk_idle_pct = 78;
        hold_request = 1'b1;
        send_tick();                  // reset state on a tick
        send_header();
        send_byte(8'h05);             // command code before any wake: back to hunting
        send_byte(HDR0);
        send_byte(HDR0);              // repeated first header byte is not re-matched
        send_header();
        send_byte(WAKE_CODE);         // arm
        send_header();
        send_byte(8'h00);             // codes out of range: hold position while armed
        send_byte(CODE_LIMIT);
        send_byte(8'h3F);
        send_byte(SEP_BYTE);
        send_byte(DATA_LOW);          // data out of range at both edges: hold
        send_byte(DATA_LIMIT);
        send_byte(8'h22);
        wait_drained();

        run_phase(20, 78, 330);
        wait_drained();
        run_phase(78, 20, 330);
        wait_drained();

        // Back-to-back phase; a short tick burst after a wake, then a command at the limits
        src_idle_pct = 0;
        snk_idle_pct = 0;
        send_header();
        send_byte(WAKE_CODE);
        repeat (21) send_tick();
        send_header();
        send_byte(8'h3F);
        send_byte(SEP_BYTE);
        send_byte(8'h5F);
        run_phase(0, 0, 330);
        wait_drained();

        if (frame_check.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/vcfp_pkg.sv
hw/rtl/vcfp_parser.sv
hw/rtl/vcfp_timer.sv
hw/rtl/voice_command_frame_parser.sv
hw/rtl/vcfp_checker.sv
sim/tb_top.sv
